/* src/i2a_pkg.sv */
package i2a_pkg;

	localparam int VALUE_BITS_DEF = 64;
	localparam int MAX_FIELD_DEF  = 64;

	// Width of field positions and segment boundaries inside the formatter.
	localparam int POS_W = 8;

	localparam logic [2:0] CONV_SDEC  = 3'd0;
	localparam logic [2:0] CONV_UDEC  = 3'd1;
	localparam logic [2:0] CONV_OCT   = 3'd2;
	localparam logic [2:0] CONV_HEXL  = 3'd3;
	localparam logic [2:0] CONV_HEXU  = 3'd4;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_UA    = 8'h41;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] r;
		if (d < 4'd10) begin
			r = CH_ZERO + {4'd0, d};
		end else begin
			r = (upper ? CH_UA : CH_LA) + {4'd0, d} - 8'd10;
		end
		return r;
	endfunction

endpackage

/* src/integer_to_ascii_formatter_top.sv */
// Formats one integer request as the characters printf would give for %d, %u, %o, %x
// or %X, one character per cycle on the output while out_stall is low, with last set on
// the final one. A request passes a masking stage, a negation stage, one binary-to-BCD
// stage per value bit, a digit count stage and a layout stage; the character emitter then
// walks its field, and further requests stream in behind it. A request whose field is
// empty, or with an unused conversion code, gives no output at all.
module integer_to_ascii_formatter_top #(
	parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF,
	parameter int MAX_FIELD  = i2a_pkg::MAX_FIELD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] value_bits,
	input  logic [1:0]  arg_size,
	input  logic [2:0]  conversion,
	input  logic        left_align,
	input  logic        force_sign,
	input  logic        space_sign,
	input  logic        alt_form,
	input  logic        zero_pad,
	input  logic [6:0]  field_width,
	input  logic [5:0]  precision,
	input  logic        has_precision,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  character,
	output logic        last
);

	localparam int ND  = (VALUE_BITS + 2) / 3;
	localparam int DW  = ND * 4;
	localparam int VIW = $clog2(VALUE_BITS);
	localparam int IW  = $clog2(ND);
	localparam int PW  = i2a_pkg::POS_W;

	typedef struct packed {
		logic [2:0] conv;
		logic       left;
		logic       plus;
		logic       space;
		logic       alt;
		logic       zpad;
		logic       hasp;
		logic [6:0] fw;
		logic [5:0] prec;
	} fmt_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] mag;
		logic [DW-1:0]         bcd;
		logic                  neg;
		fmt_t                  fmt;
	} dab_t;

	logic adv;

	// Stage 1: cut the argument to its size and find its sign.
	logic [7:0]            sz_raw, sz_in, sb_in;
	logic [VALUE_BITS-1:0] mask_in, v_in;
	fmt_t                  fmt_in;
	logic                  vld_s1;
	logic [VALUE_BITS-1:0] v_s1, mask_s1;
	logic                  neg_s1;
	fmt_t                  fmt_s1;

	always_comb begin
		sz_raw = 8'd8 << arg_size;
		sz_in  = (sz_raw > 8'(VALUE_BITS)) ? 8'(VALUE_BITS) : sz_raw;
		sb_in  = sz_in - 8'd1;
		for (int i = 0; i < VALUE_BITS; i++) begin
			mask_in[i] = (8'(i) < sz_in);
		end
		v_in = value_bits[VALUE_BITS-1:0] & mask_in;
		fmt_in.conv  = conversion;
		fmt_in.left  = left_align;
		fmt_in.plus  = force_sign;
		fmt_in.space = space_sign;
		fmt_in.alt   = alt_form;
		fmt_in.zpad  = zero_pad;
		fmt_in.hasp  = has_precision;
		fmt_in.fw    = field_width;
		fmt_in.prec  = precision;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s1    <= v_in;
			mask_s1 <= mask_in;
			neg_s1  <= (conversion == i2a_pkg::CONV_SDEC) && v_in[sb_in[VIW-1:0]];
			fmt_s1  <= fmt_in;
		end
	end

	// Magnitude stage followed by one double-dabble stage per value bit.
	dab_t dab_s  [0:VALUE_BITS];
	logic dvld_s [0:VALUE_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvld_s[0] <= 1'b0;
		end else if (adv) begin
			dvld_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dab_s[0].mag <= neg_s1 ? ((~v_s1 + 1'b1) & mask_s1) : v_s1;
			dab_s[0].bcd <= '0;
			dab_s[0].neg <= neg_s1;
			dab_s[0].fmt <= fmt_s1;
		end
	end

	for (genvar j = 0; j < VALUE_BITS; j++) begin : g_dab
		logic [DW-1:0] corr;

		always_comb begin
			for (int d = 0; d < ND; d++) begin
				corr[4*d +: 4] = (dab_s[j].bcd[4*d +: 4] >= 4'd5) ?
					dab_s[j].bcd[4*d +: 4] + 4'd3 : dab_s[j].bcd[4*d +: 4];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvld_s[j+1] <= 1'b0;
			end else if (adv) begin
				dvld_s[j+1] <= dvld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dab_s[j+1].mag <= dab_s[j].mag;
				dab_s[j+1].bcd <= {corr[DW-2:0], dab_s[j].mag[VALUE_BITS-1-j]};
				dab_s[j+1].neg <= dab_s[j].neg;
				dab_s[j+1].fmt <= dab_s[j].fmt;
			end
		end
	end

	// Stage 3: pick the digits for the base and count them.
	dab_t            dl;
	logic [ND*3-1:0] m3;
	logic [DW-1:0]   m4, dig_c;
	logic [PW-1:0]   hi_c, nd_c;
	logic [5:0]      prec_c;
	logic            zero_c;
	logic            vld_s3, zero_s3, neg_s3;
	logic [DW-1:0]   dig_s3;
	logic [PW-1:0]   nd_s3;
	fmt_t            fmt_s3;

	always_comb begin
		dl = dab_s[VALUE_BITS];
		m3 = (ND*3)'(dl.mag);
		m4 = DW'(dl.mag);
		case (dl.fmt.conv)
			i2a_pkg::CONV_OCT: begin
				for (int i = 0; i < ND; i++) begin
					dig_c[4*i +: 4] = {1'b0, m3[3*i +: 3]};
				end
			end
			i2a_pkg::CONV_HEXL, i2a_pkg::CONV_HEXU: dig_c = m4;
			default: dig_c = dl.bcd;
		endcase
		hi_c = '0;
		for (int i = 0; i < ND; i++) begin
			if (dig_c[4*i +: 4] != 4'd0) begin
				hi_c = PW'(i + 1);
			end
		end
		zero_c = (dl.mag == '0);
		prec_c = dl.fmt.hasp ? dl.fmt.prec : 6'd1;
		if (zero_c && prec_c == 6'd0) begin
			nd_c = '0;
		end else if (hi_c == '0) begin
			nd_c = PW'(1);
		end else begin
			nd_c = hi_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= dvld_s[VALUE_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dig_s3  <= dig_c;
			nd_s3   <= nd_c;
			zero_s3 <= zero_c;
			neg_s3  <= dl.neg;
			fmt_s3  <= dl.fmt;
		end
	end

	// Stage 4: lay out the field as segment boundaries.
	logic [PW-1:0] prec4, zeros4, plen4, width4, body4, pad4, lead4, zc4, trail4;
	logic [PW-1:0] b1_c, b2_c, b3_c, b4_c, tot_c;
	logic [7:0]    pre0_c, pre1_c;
	logic          zmode4;
	logic          vld_s4, upper_s4;
	logic [PW-1:0] b1_s4, b2_s4, b3_s4, b4_s4, tot_s4;
	logic [7:0]    pre0_s4, pre1_s4;
	logic [DW-1:0] dig_s4;

	always_comb begin
		prec4  = fmt_s3.hasp ? PW'(fmt_s3.prec) : PW'(1);
		zeros4 = (prec4 > nd_s3) ? prec4 - nd_s3 : '0;
		plen4  = '0;
		pre0_c = i2a_pkg::CH_ZERO;
		pre1_c = i2a_pkg::CH_LX;
		if (fmt_s3.conv == i2a_pkg::CONV_SDEC) begin
			if (neg_s3) begin
				plen4  = PW'(1);
				pre0_c = i2a_pkg::CH_MINUS;
			end else if (fmt_s3.plus) begin
				plen4  = PW'(1);
				pre0_c = i2a_pkg::CH_PLUS;
			end else if (fmt_s3.space) begin
				plen4  = PW'(1);
				pre0_c = i2a_pkg::CH_SPACE;
			end
		end else if (fmt_s3.alt && fmt_s3.conv == i2a_pkg::CONV_OCT) begin
			// A leading zero is added only if the digits do not already start with one.
			if (zeros4 == '0 && !(nd_s3 == PW'(1) && zero_s3)) begin
				zeros4 = PW'(1);
			end
		end else if (fmt_s3.alt && !zero_s3 && (fmt_s3.conv == i2a_pkg::CONV_HEXL ||
				fmt_s3.conv == i2a_pkg::CONV_HEXU)) begin
			plen4  = PW'(2);
			pre1_c = (fmt_s3.conv == i2a_pkg::CONV_HEXU) ? i2a_pkg::CH_UX : i2a_pkg::CH_LX;
		end
		width4 = (PW'(fmt_s3.fw) > PW'(MAX_FIELD)) ? PW'(MAX_FIELD) : PW'(fmt_s3.fw);
		body4  = plen4 + zeros4 + nd_s3;
		pad4   = (width4 > body4) ? width4 - body4 : '0;
		zmode4 = !fmt_s3.left && fmt_s3.zpad && !fmt_s3.hasp;
		lead4  = (!fmt_s3.left && !zmode4) ? pad4 : '0;
		zc4    = zeros4 + (zmode4 ? pad4 : '0);
		trail4 = fmt_s3.left ? pad4 : '0;
		b1_c   = lead4;
		b2_c   = b1_c + plen4;
		b3_c   = b2_c + zc4;
		b4_c   = b3_c + nd_s3;
		tot_c  = b4_c + trail4;
		if (tot_c > PW'(MAX_FIELD)) begin
			tot_c = PW'(MAX_FIELD);
		end
		if (fmt_s3.conv > i2a_pkg::CONV_HEXU) begin
			tot_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b1_s4    <= b1_c;
			b2_s4    <= b2_c;
			b3_s4    <= b3_c;
			b4_s4    <= b4_c;
			tot_s4   <= tot_c;
			pre0_s4  <= pre0_c;
			pre1_s4  <= pre1_c;
			dig_s4   <= dig_s3;
			upper_s4 <= (fmt_s3.conv == i2a_pkg::CONV_HEXU);
		end
	end

	// Character emitter: walks the field one position per cycle while the output is not stalled.
	logic          e_vld_q, e_upper_q;
	logic [PW-1:0] k_q, e_b1_q, e_b2_q, e_b3_q, e_b4_q, e_tot_q;
	logic [7:0]    e_pre0_q, e_pre1_q;
	logic [DW-1:0] e_dig_q;
	logic          out_free, emit_fire, e_last, emit_load;
	logic [PW-1:0] didx;
	logic [7:0]    ch_c;

	assign out_free  = !out_valid || !out_stall;
	assign emit_fire = e_vld_q && out_free;
	assign e_last    = (k_q + PW'(1) == e_tot_q);
	assign emit_load = !e_vld_q || (emit_fire && e_last);
	assign adv       = !vld_s4 || emit_load;
	assign in_stall  = !adv;

	always_comb begin
		didx = e_b4_q - PW'(1) - k_q;
		if (k_q < e_b1_q) begin
			ch_c = i2a_pkg::CH_SPACE;
		end else if (k_q < e_b2_q) begin
			ch_c = (k_q == e_b1_q) ? e_pre0_q : e_pre1_q;
		end else if (k_q < e_b3_q) begin
			ch_c = i2a_pkg::CH_ZERO;
		end else if (k_q < e_b4_q) begin
			ch_c = i2a_pkg::digit_char(e_dig_q[4*didx[IW-1:0] +: 4], e_upper_q);
		end else begin
			ch_c = i2a_pkg::CH_SPACE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_vld_q   <= 1'b0;
			k_q       <= '0;
			out_valid <= 1'b0;
		end else begin
			if (emit_load) begin
				e_vld_q <= vld_s4 && (tot_s4 != '0);
				k_q     <= '0;
			end else if (emit_fire) begin
				k_q <= k_q + PW'(1);
			end
			if (emit_fire) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			e_b1_q    <= b1_s4;
			e_b2_q    <= b2_s4;
			e_b3_q    <= b3_s4;
			e_b4_q    <= b4_s4;
			e_tot_q   <= tot_s4;
			e_pre0_q  <= pre0_s4;
			e_pre1_q  <= pre1_s4;
			e_dig_q   <= dig_s4;
			e_upper_q <= upper_s4;
		end
		if (emit_fire) begin
			character <= ch_c;
			last      <= e_last;
		end
	end

endmodule
